>>> rtl/lbcd_pkg.sv
// Package for the LRU block cache directory: field widths, status codes and defaults.
// Used by lru_block_cache_directory_unit; has no dependencies of its own.
package lbcd_pkg;

	localparam int KEY_W          = 31;
	localparam int BLOCK_W        = 32;
	localparam int CAP_W          = 5;
	localparam int SLOT_W         = 4;
	localparam int STATUS_W       = 2;
	localparam int MAX_ENTRIES_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS   = 2'd2;

endpackage

>>> rtl/lru_block_cache_directory_unit.sv
// Top level of the fully associative LRU block cache directory.
// Depends on lbcd_pkg and instantiates lbcd_ram for the key and recency storage.
//
// A request with a block number of zero or below goes straight to the final state and
// is answered with a rejected status, leaving the directory unchanged. Any other
// request is served in two passes, with the read port of the entry RAM reading one
// entry per cycle: first a search pass over all entries that finds the hit, the
// least recently used entry and a free entry, then an update pass that ages the
// affected entries and writes the new most recently used one.
// The block takes no new transaction while a request is in progress, and a result
// that is still waiting for out_ready holds the next one in its final state. The
// capacity register may be written at any time the block is idle; zero acts as one
// and values above MAX_ENTRIES act as MAX_ENTRIES.
module lru_block_cache_directory_unit #(
	parameter int MAX_ENTRIES = lbcd_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lbcd_pkg::CAP_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [lbcd_pkg::BLOCK_W-1:0] block_number,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lbcd_pkg::STATUS_W-1:0]     status,
	output logic [lbcd_pkg::SLOT_W-1:0]       slot,
	output logic                              evicted_valid,
	output logic [lbcd_pkg::KEY_W-1:0]        evicted_block
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RW = IW;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (CW > lbcd_pkg::CAP_W) ? CW : lbcd_pkg::CAP_W;
	localparam int KW = lbcd_pkg::KEY_W;
	localparam int DW = KW + RW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0]                 st_q;
	logic [lbcd_pkg::CAP_W-1:0] cap_q;
	logic [MAX_ENTRIES-1:0]     valid_q;
	logic [CW-1:0]              count_q;
	logic [KW-1:0]              key_q;
	logic [IW:0]                cnt_q;
	logic                       rv_s1;
	logic [IW-1:0]              ri_s1;

	logic                       hit_q;
	logic [IW-1:0]              hslot_q;
	logic [RW-1:0]              hrank_q;
	logic                       found_q;
	logic [IW-1:0]              bslot_q;
	logic [RW-1:0]              brank_q;
	logic [KW-1:0]              bkey_q;
	logic                       free_q;
	logic [IW-1:0]              fslot_q;

	logic [IW-1:0]              target_q;
	logic                       all_q;
	logic [RW-1:0]              limit_q;
	logic                       evict_q;
	logic [lbcd_pkg::STATUS_W-1:0] res_status_q;

	logic                       out_valid_q;
	logic [lbcd_pkg::STATUS_W-1:0] status_q;
	logic [lbcd_pkg::SLOT_W-1:0]   slot_q;
	logic                       ev_valid_q;
	logic [KW-1:0]              ev_block_q;

	logic                       ram_we;
	logic [DW-1:0]              ram_wdata;
	logic [DW-1:0]              ram_rdata;
	logic [KW-1:0]              rd_key;
	logic [RW-1:0]              rd_rank;
	logic                       rd_valid;
	logic                       reject;
	logic                       cnt_live;
	logic                       out_free;
	logic [EW-1:0]              cap_e;
	logic [EW-1:0]              eff_cap;
	logic                       full;

	assign rd_key   = ram_rdata[DW-1:RW];
	assign rd_rank  = ram_rdata[RW-1:0];
	assign rd_valid = valid_q[ri_s1];
	assign reject   = block_number[lbcd_pkg::BLOCK_W-1] || (block_number == '0);
	assign cnt_live = cnt_q < (IW+1)'(MAX_ENTRIES);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (st_q == ST_IDLE);

	always_comb begin
		cap_e   = EW'(cap_q);
		eff_cap = cap_e;
		if (cap_e == '0) begin
			eff_cap = EW'(1);
		end else if (cap_e > EW'(MAX_ENTRIES)) begin
			eff_cap = EW'(MAX_ENTRIES);
		end
		full = (EW'(count_q) >= eff_cap) && (count_q != '0);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = {rd_key, RW'(rd_rank + 1'b1)};
		if (st_q == ST_UPDATE && rv_s1) begin
			if (ri_s1 == target_q) begin
				ram_we    = 1'b1;
				ram_wdata = {key_q, {RW{1'b0}}};
			end else if (rd_valid && (all_q || rd_rank < limit_q)) begin
				ram_we = 1'b1;
			end
		end
	end

	lbcd_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ri_s1),
		.wdata(ram_wdata),
		.raddr(cnt_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cap_q       <= lbcd_pkg::CAP_RESET;
			valid_q     <= '0;
			count_q     <= '0;
			cnt_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (st_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					rv_s1 <= 1'b0;
					if (in_valid) begin
						cnt_q <= '0;
						st_q  <= reject ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					rv_s1 <= cnt_live;
					cnt_q <= cnt_q + 1'b1;
					if (!cnt_live) begin
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					rv_s1 <= 1'b0;
					cnt_q <= '0;
					st_q  <= ST_UPDATE;
					if (!hit_q && !full) begin
						valid_q[fslot_q] <= 1'b1;
						count_q          <= CW'(count_q + 1'b1);
					end
				end
				ST_UPDATE: begin
					rv_s1 <= cnt_live;
					cnt_q <= cnt_q + 1'b1;
					if (!cnt_live) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					rv_s1 <= 1'b0;
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					rv_s1 <= 1'b0;
					st_q  <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= cnt_q[IW-1:0];
		case (st_q)
			ST_IDLE: begin
				key_q        <= block_number[KW-1:0];
				hit_q        <= 1'b0;
				found_q      <= 1'b0;
				free_q       <= 1'b0;
				evict_q      <= 1'b0;
				target_q     <= '0;
				bkey_q       <= '0;
				res_status_q <= lbcd_pkg::STATUS_REJECT;
			end
			ST_SCAN: begin
				if (rv_s1) begin
					if (rd_valid && rd_key == key_q && !hit_q) begin
						hit_q   <= 1'b1;
						hslot_q <= ri_s1;
						hrank_q <= rd_rank;
					end
					if (rd_valid && (!found_q || rd_rank > brank_q)) begin
						found_q <= 1'b1;
						bslot_q <= ri_s1;
						brank_q <= rd_rank;
						bkey_q  <= rd_key;
					end
					if (!rd_valid && !free_q) begin
						free_q  <= 1'b1;
						fslot_q <= ri_s1;
					end
				end
			end
			ST_DECIDE: begin
				if (hit_q) begin
					target_q     <= hslot_q;
					all_q        <= 1'b0;
					limit_q      <= hrank_q;
					res_status_q <= lbcd_pkg::STATUS_HIT;
				end else begin
					target_q     <= full ? bslot_q : fslot_q;
					all_q        <= 1'b1;
					limit_q      <= '0;
					evict_q      <= full;
					res_status_q <= lbcd_pkg::STATUS_MISS;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					status_q   <= res_status_q;
					slot_q     <= lbcd_pkg::SLOT_W'(target_q);
					ev_valid_q <= evict_q;
					ev_block_q <= evict_q ? bkey_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_block = ev_block_q;

endmodule

>>> rtl/lbcd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are undefined until written.
module lbcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/lru_block_cache_directory_unit_tb.sv
// Self-checking testbench for lru_block_cache_directory_unit: directed table, then random traffic.
// Keeps its own LRU directory model to predict every result the table does not give; needs lbcd_pkg and the RTL only.
// Runs three idle patterns on both handshakes and rewrites the capacity before each chunk of random traffic.
module lru_block_cache_directory_unit_tb;

	localparam int N_SLOTS          = lbcd_pkg::MAX_ENTRIES_DEF;
	localparam int LATENCY          = 2 * N_SLOTS + 4;
	localparam int SETTLE_CYCLES    = 4;
	localparam int STALL_LIMIT      = 2000;
	localparam int POOL_SIZE        = 24;
	localparam int CHUNK_ITEMS      = 71;
	localparam int CHUNKS_PER_PHASE = 4;
	localparam int unsigned AGE_TOP = 32'hFFFF;
	localparam int DIRECTED_ROWS    = 26;

	typedef struct packed {
		logic [lbcd_pkg::STATUS_W-1:0] status;
		logic [lbcd_pkg::SLOT_W-1:0]   slot;
		logic                          ev_valid;
		logic [lbcd_pkg::KEY_W-1:0]    ev_block;
	} dir_result_t;

	typedef struct packed {
		logic                         is_cfg;
		logic [lbcd_pkg::BLOCK_W-1:0] value;
		logic                         typed;
		dir_result_t                  want;
	} plan_row_t;

	localparam dir_result_t NO_RESULT = '0;
	localparam dir_result_t REJECTED  =
		dir_result_t'{lbcd_pkg::STATUS_REJECT, 4'd0, 1'b0, 31'd0};

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [lbcd_pkg::CAP_W-1:0]          cfg_wdata = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [lbcd_pkg::BLOCK_W-1:0] block_number = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [lbcd_pkg::STATUS_W-1:0]       status;
	logic [lbcd_pkg::SLOT_W-1:0]         slot;
	logic                                evicted_valid;
	logic [lbcd_pkg::KEY_W-1:0]          evicted_block;

	bit                         tag_valid [N_SLOTS];
	logic [lbcd_pkg::KEY_W-1:0] tag_key [N_SLOTS];
	int unsigned                tag_age [N_SLOTS];
	int unsigned                tags_held = 0;
	logic [lbcd_pkg::CAP_W-1:0] cap_setting = lbcd_pkg::CAP_RESET;

	dir_result_t                  pending_results [$];
	logic [lbcd_pkg::BLOCK_W-1:0] hot_pool [POOL_SIZE];
	int unsigned                  pool_span = POOL_SIZE;
	int unsigned                  snd_idle_pct = 7;
	int unsigned                  rcv_idle_pct = 70;
	int unsigned                  n_errors = 0;
	int unsigned                  quiet_cycles = 0;

	plan_row_t directed_plan [DIRECTED_ROWS] = '{
		'{1'b0, 32'h0000_0000, 1'b1, REJECTED},
		'{1'b0, 32'hFFFF_FFFF, 1'b1, REJECTED},
		'{1'b0, 32'h8000_0000, 1'b1, REJECTED},
		'{1'b0, 32'h0000_0001, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_MISS, 4'd0, 1'b0, 31'd0}},
		'{1'b0, 32'h7FFF_FFFF, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_MISS, 4'd1, 1'b0, 31'd0}},
		'{1'b0, 32'h0000_0001, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_HIT, 4'd0, 1'b0, 31'd0}},
		'{1'b0, 32'h7FFF_FFFF, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_HIT, 4'd1, 1'b0, 31'd0}},
		'{1'b0, 32'h0000_0002, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_MISS, 4'd2, 1'b0, 31'd0}},
		'{1'b0, 32'h0000_0003, 1'b1,
			dir_result_t'{lbcd_pkg::STATUS_MISS, 4'd3, 1'b0, 31'd0}},
		'{1'b1, 32'd2,         1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0009, 1'b0, NO_RESULT},
		'{1'b0, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0001, 1'b0, NO_RESULT},
		'{1'b1, 32'd0,         1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0004, 1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0004, 1'b0, NO_RESULT},
		'{1'b0, 32'h8000_0001, 1'b1, REJECTED},
		'{1'b1, 32'd31,        1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0005, 1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0006, 1'b0, NO_RESULT},
		'{1'b0, 32'h7FFF_FFFE, 1'b0, NO_RESULT},
		'{1'b1, 32'd1,         1'b0, NO_RESULT},
		'{1'b0, 32'h5555_5555, 1'b0, NO_RESULT},
		'{1'b0, 32'h2AAA_AAAA, 1'b0, NO_RESULT},
		'{1'b0, 32'h5555_5555, 1'b0, NO_RESULT},
		'{1'b1, 32'd16,        1'b0, NO_RESULT}
	};

	lru_block_cache_directory_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.block_number  (block_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot          (slot),
		.evicted_valid (evicted_valid),
		.evicted_block (evicted_block)
	);

	always #4 clk = ~clk;

	function automatic void bump_ages(input int s, input int unsigned limit);
		for (int i = 0; i < N_SLOTS; i++) begin
			if (tag_valid[i] && i != s && tag_age[i] < limit)
				tag_age[i] = tag_age[i] + 1;
		end
		tag_age[s] = 0;
	endfunction

	function automatic dir_result_t predict_lookup(input logic [lbcd_pkg::BLOCK_W-1:0] req);
		dir_result_t                r;
		logic [lbcd_pkg::KEY_W-1:0] key;
		int                         idx;
		bit                         found;
		int unsigned                cap_eff;
		r = '0;
		key = req[lbcd_pkg::KEY_W-1:0];
		if (req[lbcd_pkg::BLOCK_W-1] || req == '0) begin
			r.status = lbcd_pkg::STATUS_REJECT;
			return r;
		end
		cap_eff = (cap_setting == 0) ? 1 : (cap_setting > N_SLOTS) ? N_SLOTS : cap_setting;
		found = 1'b0;
		idx = 0;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (!found && tag_valid[i] && tag_key[i] == key) begin
				found = 1'b1;
				idx = i;
			end
		end
		if (found) begin
			bump_ages(idx, tag_age[idx]);
			r.status = lbcd_pkg::STATUS_HIT;
		end else begin
			found = 1'b0;
			if (tags_held >= cap_eff && tags_held > 0) begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (tag_valid[i] && (!found || tag_age[i] > tag_age[idx])) begin
						idx = i;
						found = 1'b1;
					end
				end
				r.ev_valid = 1'b1;
				r.ev_block = tag_key[idx];
			end else begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (!found && !tag_valid[i]) begin
						idx = i;
						found = 1'b1;
					end
				end
				tag_valid[idx] = 1'b1;
				tags_held = tags_held + 1;
			end
			bump_ages(idx, AGE_TOP);
			tag_key[idx] = key;
			r.status = lbcd_pkg::STATUS_MISS;
		end
		r.slot = idx[lbcd_pkg::SLOT_W-1:0];
		return r;
	endfunction

	function automatic logic [lbcd_pkg::BLOCK_W-1:0] pick_block();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 12)
			return $urandom | 32'h8000_0000;
		if (roll < 20)
			return $urandom;
		return hot_pool[$urandom_range(0, pool_span - 1)];
	endfunction

	function automatic void report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_block(input logic [lbcd_pkg::BLOCK_W-1:0] value, input logic typed,
			input dir_result_t want);
		dir_result_t forecast;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		block_number <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		forecast = predict_lookup(value);
		pending_results.push_back(typed ? want : forecast);
	endtask

	task automatic write_capacity(input logic [lbcd_pkg::CAP_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_setting = value;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

	always @(posedge clk) begin : check_results
		dir_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected transaction, expected none, got status %0d slot %0d",
					$time, status, slot);
			end else begin
				want = pending_results.pop_front();
				report_field("status", 32'(want.status), 32'(status));
				report_field("slot", 32'(want.slot), 32'(slot));
				report_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
				report_field("evicted_block", 32'(want.ev_block), 32'(evicted_block));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [lbcd_pkg::CAP_W-1:0] next_cap;
		for (int i = 0; i < POOL_SIZE; i++)
			hot_pool[i] = (i < 8) ? i + 1 : (($urandom & 32'h7FFF_FFFF) | 32'd1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[r]) begin
			if (directed_plan[r].is_cfg)
				write_capacity(directed_plan[r].value[lbcd_pkg::CAP_W-1:0]);
			else
				send_block(directed_plan[r].value, directed_plan[r].typed, directed_plan[r].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 7;
					rcv_idle_pct = 70;
				end
				1: begin
					snd_idle_pct = 70;
					rcv_idle_pct = 7;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
				case ($urandom_range(0, 5))
					0: next_cap = 5'd0;
					1: next_cap = 5'd1;
					2: next_cap = 5'd16;
					3: next_cap = 5'd31;
					default: next_cap = lbcd_pkg::CAP_W'($urandom_range(0, 31));
				endcase
				write_capacity(next_cap);
				pool_span = $urandom_range(2, POOL_SIZE);
				for (int k = 0; k < CHUNK_ITEMS; k++)
					send_block(pick_block(), 1'b0, NO_RESULT);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + SETTLE_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lbcd_pkg.sv
rtl/lbcd_ram.sv
rtl/lru_block_cache_directory_unit.sv
tb/sv/lru_block_cache_directory_unit_tb.sv
